/* rtl/pds_pkg.sv */
// Package with the shared types and constants of the packet direction statistics block.
package pds_pkg;

  localparam int NUM_CLASSES  = 3;
  localparam int NUM_COUNTERS = 7;
  localparam int BIN_W        = 32;
  localparam int CNT_W        = 48;
  localparam int CFG_W        = 32;

  typedef enum logic [1:0] {
    CMD_RECORD    = 2'd0,
    CMD_READ_CNT  = 2'd1,
    CMD_READ_SIZE = 2'd2,
    CMD_READ_PAY  = 2'd3
  } cmd_t;

  localparam logic [1:0] CLS_OUT   = 2'd0;
  localparam logic [1:0] CLS_IN    = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;
  localparam logic [1:0] CLS_SUM   = 2'd3;

  localparam logic [1:0] PROTO_TCP = 2'd1;
  localparam logic [1:0] PROTO_UDP = 2'd2;

  localparam logic [2:0] CNT_PKTS     = 3'd0;
  localparam logic [2:0] CNT_BYTES    = 3'd1;
  localparam logic [2:0] CNT_PAYLOAD  = 3'd2;
  localparam logic [2:0] CNT_FLAG0    = 3'd3;
  localparam logic [2:0] CNT_RST      = 3'd6;
  localparam logic [2:0] CNT_DURATION = 3'd7;

  localparam logic CFG_REF_IP = 1'b0;
  localparam logic CFG_SWAP   = 1'b1;

  typedef logic [NUM_CLASSES-1:0][BIN_W-1:0] bin_row_t;

  typedef struct packed {
    logic       rd_en;
    logic       upd_en;
    logic       clr_en;
    logic [1:0] lane;
  } bin_ctl_t;

endpackage

/* rtl/pds_if.sv */
// Channel interfaces for packet items and for results.
interface pds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] frame_len;
  logic [15:0] ip_len;
  logic [15:0] payload_len;
  logic [1:0]  proto_kind;
  logic [3:0]  tcp_flags;
  logic [47:0] time_us;
  logic [1:0]  read_class;
  logic [10:0] read_index;

  modport source (output valid, command, src_ip, dst_ip, frame_len, ip_len, payload_len,
                  proto_kind, tcp_flags, time_us, read_class, read_index, input ready);
  modport sink (input valid, command, src_ip, dst_ip, frame_len, ip_len, payload_len,
                proto_kind, tcp_flags, time_us, read_class, read_index, output ready);
endinterface

interface pds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  direction;
  logic [47:0] read_value;

  modport source (output valid, direction, read_value, input ready);
  modport sink (input valid, direction, read_value, output ready);
endinterface

/* rtl/pds_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module pds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pds_bin_unit.sv */
// Histogram row store: RAM with one row per bin, forwarding and per-class increment.
module pds_bin_unit #(
  parameter int NUM_BINS = 1501
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pds_pkg::bin_ctl_t           ctl,
  input  logic [$clog2(NUM_BINS)-1:0] rd_addr,
  input  logic [$clog2(NUM_BINS)-1:0] clr_addr,
  output pds_pkg::bin_row_t           row
);

  localparam int AW = $clog2(NUM_BINS);

  logic [AW-1:0]     addr_r;
  logic              hit_r;
  pds_pkg::bin_row_t fwd_r;
  pds_pkg::bin_row_t ram_rdata;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  pds_pkg::bin_row_t wr_data;

  pds_ram #(
    .WIDTH (pds_pkg::NUM_CLASSES * pds_pkg::BIN_W),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // A row written in the same cycle as it is read comes back stale from the RAM.
  assign row     = hit_r ? fwd_r : ram_rdata;
  assign wr_en   = ctl.clr_en | ctl.upd_en;
  assign wr_addr = ctl.clr_en ? clr_addr : addr_r;

  always_comb begin
    wr_data = row;
    for (int l = 0; l < pds_pkg::NUM_CLASSES; l++) begin
      if (2'(l) == ctl.lane) begin
        wr_data[l] = row[l] + pds_pkg::BIN_W'(1);
      end
    end
    if (ctl.clr_en) begin
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.rd_en) begin
      hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      addr_r <= rd_addr;
      fwd_r  <= wr_data;
    end
  end

endmodule

/* rtl/packet_direction_statistics_top.sv */
// Top level of the packet direction statistics block.
// Each item passes through the update stage and then the result register. Throughput:
// one item per cycle while the result channel is not stalled; the bin memories are read
// when an item is taken and written back as it leaves the update stage, with forwarding
// between consecutive items. Reset: counters and timestamps clear at once; the bin
// memories are then cleared one row a cycle, all NUM_BINS rows, during which no item is taken.
module packet_direction_statistics_top #(
  parameter int NUM_BINS = 1501
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pds_in_if.sink                    in_ch,
  pds_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [pds_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int AW       = $clog2(NUM_BINS);
  localparam int LAST_BIN = NUM_BINS - 1;
  localparam int CW       = pds_pkg::CNT_W;
  localparam int NC       = pds_pkg::NUM_CLASSES;
  localparam int NK       = pds_pkg::NUM_COUNTERS;

  // Configuration.
  logic [31:0] ref_ip_r;
  logic        swap_r;

  // Clearing pass.
  logic          clear_r;
  logic [AW-1:0] clr_cnt_r;

  // Issue stage.
  logic          accept;
  logic [1:0]    cls_in;
  logic [AW-1:0] size_addr;
  logic [AW-1:0] pay_addr;
  logic          bin_ok;

  // Update stage.
  logic          s1_valid_r;
  pds_pkg::cmd_t s1_cmd_r;
  logic [1:0]    s1_cls_r;
  logic [15:0]   s1_frame_r;
  logic [15:0]   s1_pay_r;
  logic [1:0]    s1_proto_r;
  logic [3:0]    s1_flags_r;
  logic [47:0]   s1_time_r;
  logic [1:0]    s1_rclass_r;
  logic [2:0]    s1_cidx_r;
  logic          s1_cok_r;
  logic          s1_bok_r;
  logic          adv;
  logic          commit;
  logic          commit_rec;
  logic          tcp_udp;
  logic          is_tcp;

  // State.
  logic [CW-1:0] cnt_r   [NK][NC];
  logic [CW-1:0] cnt_nxt [NK][NC];
  logic [47:0]   first_r;
  logic [47:0]   last_r;
  logic          seen_r;

  // Bin memories.
  pds_pkg::bin_ctl_t size_ctl;
  pds_pkg::bin_ctl_t pay_ctl;
  pds_pkg::bin_row_t size_row;
  pds_pkg::bin_row_t pay_row;

  // Result register.
  logic          out_valid_r;
  logic [1:0]    out_dir_r;
  logic [47:0]   out_val_r;
  logic [47:0]   val_nxt;
  logic [CW-1:0] cnt_sel [NC];
  pds_pkg::bin_row_t bin_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_ip_r <= '0;
      swap_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pds_pkg::CFG_REF_IP: ref_ip_r <= cfg_wdata;
        pds_pkg::CFG_SWAP:   swap_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(LAST_BIN)) begin
        clear_r <= 1'b0;
      end
    end
  end

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !clear_r && (adv || !s1_valid_r);
  assign accept       = in_ch.valid && in_ch.ready;
  assign commit       = s1_valid_r && adv;
  assign commit_rec   = commit && (s1_cmd_r == pds_pkg::CMD_RECORD);
  assign tcp_udp      = (s1_proto_r == pds_pkg::PROTO_TCP) || (s1_proto_r == pds_pkg::PROTO_UDP);
  assign is_tcp       = s1_proto_r == pds_pkg::PROTO_TCP;

  always_comb begin
    if (in_ch.src_ip == ref_ip_r) begin
      cls_in = pds_pkg::CLS_OUT ^ {1'b0, swap_r};
    end else if (in_ch.dst_ip == ref_ip_r) begin
      cls_in = pds_pkg::CLS_IN ^ {1'b0, swap_r};
    end else begin
      cls_in = pds_pkg::CLS_OTHER;
    end
    bin_ok = 32'(in_ch.read_index) < 32'(NUM_BINS);
    if (pds_pkg::cmd_t'(in_ch.command) == pds_pkg::CMD_RECORD) begin
      size_addr = (32'(in_ch.ip_len) >= 32'(LAST_BIN)) ? AW'(LAST_BIN) : AW'(in_ch.ip_len);
      pay_addr  = (32'(in_ch.payload_len) >= 32'(LAST_BIN)) ? AW'(LAST_BIN)
                                                             : AW'(in_ch.payload_len);
    end else begin
      size_addr = bin_ok ? AW'(in_ch.read_index) : '0;
      pay_addr  = size_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (commit) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r    <= pds_pkg::cmd_t'(in_ch.command);
      s1_cls_r    <= cls_in;
      s1_frame_r  <= in_ch.frame_len;
      s1_pay_r    <= in_ch.payload_len;
      s1_proto_r  <= in_ch.proto_kind;
      s1_flags_r  <= in_ch.tcp_flags;
      s1_time_r   <= in_ch.time_us;
      s1_rclass_r <= in_ch.read_class;
      s1_cidx_r   <= in_ch.read_index[2:0];
      s1_cok_r    <= in_ch.read_index[10:3] == '0;
      s1_bok_r    <= bin_ok;
    end
  end

  always_comb begin
    size_ctl.rd_en  = accept;
    size_ctl.upd_en = commit_rec;
    size_ctl.clr_en = clear_r;
    size_ctl.lane   = s1_cls_r;
    pay_ctl.rd_en   = accept;
    pay_ctl.upd_en  = commit_rec && tcp_udp;
    pay_ctl.clr_en  = clear_r;
    pay_ctl.lane    = s1_cls_r;
  end

  pds_bin_unit #(.NUM_BINS (NUM_BINS)) u_size_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (size_ctl),
    .rd_addr  (size_addr),
    .clr_addr (clr_cnt_r),
    .row      (size_row)
  );

  pds_bin_unit #(.NUM_BINS (NUM_BINS)) u_pay_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pay_ctl),
    .rd_addr  (pay_addr),
    .clr_addr (clr_cnt_r),
    .row      (pay_row)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (commit_rec) begin
      for (int c = 0; c < NC; c++) begin
        if (2'(c) == s1_cls_r) begin
          cnt_nxt[pds_pkg::CNT_PKTS][c]  = cnt_r[pds_pkg::CNT_PKTS][c] + CW'(1);
          cnt_nxt[pds_pkg::CNT_BYTES][c] = cnt_r[pds_pkg::CNT_BYTES][c] + CW'(s1_frame_r);
          if (tcp_udp) begin
            cnt_nxt[pds_pkg::CNT_PAYLOAD][c] = cnt_r[pds_pkg::CNT_PAYLOAD][c] + CW'(s1_pay_r);
          end
          if (is_tcp) begin
            for (int f = 0; f < 4; f++) begin
              if (s1_flags_r[f]) begin
                cnt_nxt[int'(pds_pkg::CNT_FLAG0) + f][c] =
                  cnt_r[int'(pds_pkg::CNT_FLAG0) + f][c] + CW'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NK; k++) begin
        for (int c = 0; c < NC; c++) begin
          cnt_r[k][c] <= '0;
        end
      end
      first_r <= '0;
      last_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (commit_rec) begin
        if (!seen_r) begin
          first_r <= s1_time_r;
        end
        seen_r <= 1'b1;
        last_r <= s1_time_r;
      end
    end
  end

  // Result value of the item in the update stage.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      cnt_sel[c] = '0;
      for (int k = 0; k < NK; k++) begin
        if (3'(k) == s1_cidx_r) begin
          cnt_sel[c] = cnt_r[k][c];
        end
      end
    end
    bin_sel = (s1_cmd_r == pds_pkg::CMD_READ_SIZE) ? size_row : pay_row;
    val_nxt = '0;
    case (s1_cmd_r)
      pds_pkg::CMD_READ_CNT: begin
        if (s1_cok_r && s1_cidx_r == pds_pkg::CNT_DURATION) begin
          val_nxt = seen_r ? (last_r - first_r) : '0;
        end else if (s1_cok_r) begin
          if (s1_rclass_r == pds_pkg::CLS_SUM) begin
            val_nxt = cnt_sel[0] + cnt_sel[1] + cnt_sel[2];
          end else begin
            for (int c = 0; c < NC; c++) begin
              if (2'(c) == s1_rclass_r) begin
                val_nxt = cnt_sel[c];
              end
            end
          end
        end
      end
      pds_pkg::CMD_READ_SIZE, pds_pkg::CMD_READ_PAY: begin
        if (s1_bok_r) begin
          if (s1_rclass_r == pds_pkg::CLS_SUM) begin
            val_nxt = 48'(bin_sel[0]) + 48'(bin_sel[1]) + 48'(bin_sel[2]);
          end else begin
            for (int c = 0; c < NC; c++) begin
              if (2'(c) == s1_rclass_r) begin
                val_nxt = 48'(bin_sel[c]);
              end
            end
          end
        end
      end
      default: val_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_dir_r <= (s1_cmd_r == pds_pkg::CMD_RECORD) ? s1_cls_r : pds_pkg::CLS_OUT;
      out_val_r <= val_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.direction  = out_dir_r;
  assign out_ch.read_value = out_val_r;

  a_no_take_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_ch.ready)
    else $error("item taken during the bin clearing pass");

  a_stage_empty_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !s1_valid_r)
    else $error("update stage busy during the bin clearing pass");

  a_record_class_valid : assert property (@(posedge clk) disable iff (!rst_n)
    commit_rec |=> (out_ch.valid && out_ch.direction != pds_pkg::CLS_SUM))
    else $error("recorded packet gave an invalid direction");

endmodule

/* tb/packet_direction_statistics_top_tb.sv */
// Self-checking testbench for the packet direction statistics block, with its scoreboard.
module packet_direction_statistics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BINS = 1501;
  localparam int NCLS     = pds_pkg::NUM_CLASSES;
  localparam int NCNT     = pds_pkg::NUM_COUNTERS;

  localparam logic [1:0] PROTO_NONE    = 2'd0;
  localparam logic [1:0] PROTO_UNKNOWN = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    pds_pkg::cmd_t command;
    logic [31:0]   src_ip;
    logic [31:0]   dst_ip;
    logic [15:0]   frame_len;
    logic [15:0]   ip_len;
    logic [15:0]   payload_len;
    logic [1:0]    proto_kind;
    logic [3:0]    tcp_flags;
    logic [47:0]   time_us;
    logic [1:0]    read_class;
    logic [10:0]   read_index;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  direction;
    logic [47:0] read_value;
  } result_t;

  // Keeps its own copy of the histograms and counters and predicts every result.
  class stats_scoreboard;
    bit [31:0] ref_ip;
    bit        swap_dir;
    bit [31:0] size_hist [NCLS*NUM_BINS];
    bit [31:0] payload_hist [NCLS*NUM_BINS];
    bit [47:0] tallies [NCLS*NCNT];
    bit [47:0] first_stamp;
    bit [47:0] last_stamp;
    bit        stamped;
    result_t   awaited [$];
    int        failures;

    function void set_config(bit [31:0] ip, bit swap);
      ref_ip   = ip;
      swap_dir = swap;
    endfunction

    function int bin_of(bit [15:0] len);
      return (len >= NUM_BINS - 1) ? NUM_BINS - 1 : int'(len);
    endfunction

    function void tally(bit [1:0] cls, int which, bit [47:0] amount);
      tallies[int'(cls)*NCNT + which] += amount;
    endfunction

    function bit [1:0] record_packet(pkt_t p);
      bit [1:0] cls;
      int       row;
      if (p.src_ip == ref_ip) begin
        cls = pds_pkg::CLS_OUT ^ {1'b0, swap_dir};
      end else if (p.dst_ip == ref_ip) begin
        cls = pds_pkg::CLS_IN ^ {1'b0, swap_dir};
      end else begin
        cls = pds_pkg::CLS_OTHER;
      end
      if (!stamped) begin
        first_stamp = p.time_us;
        stamped     = 1'b1;
      end
      last_stamp = p.time_us;
      row = int'(cls) * NUM_BINS;
      size_hist[row + bin_of(p.ip_len)]++;
      tally(cls, int'(pds_pkg::CNT_PKTS), 48'd1);
      tally(cls, int'(pds_pkg::CNT_BYTES), p.frame_len);
      if (p.proto_kind == pds_pkg::PROTO_TCP || p.proto_kind == pds_pkg::PROTO_UDP) begin
        payload_hist[row + bin_of(p.payload_len)]++;
        tally(cls, int'(pds_pkg::CNT_PAYLOAD), p.payload_len);
        if (p.proto_kind == pds_pkg::PROTO_TCP) begin
          for (int f = 0; f < 4; f++) begin
            if (p.tcp_flags[f]) tally(cls, int'(pds_pkg::CNT_FLAG0) + f, 48'd1);
          end
        end
      end
      return cls;
    endfunction

    function bit [47:0] counter_value(bit [1:0] cls, bit [10:0] idx);
      bit [47:0] acc;
      acc = '0;
      // The duration is shared by all classes and wraps if time went backwards.
      if (idx == pds_pkg::CNT_DURATION) return stamped ? last_stamp - first_stamp : 48'd0;
      if (idx > pds_pkg::CNT_RST) return '0;
      if (cls != pds_pkg::CLS_SUM) return tallies[int'(cls)*NCNT + int'(idx)];
      for (int c = 0; c < NCLS; c++) acc += tallies[c*NCNT + int'(idx)];
      return acc;
    endfunction

    function bit [47:0] bin_value(bit payload, bit [1:0] cls, bit [10:0] idx);
      bit [47:0] acc;
      acc = '0;
      if (idx >= NUM_BINS) return '0;
      for (int c = 0; c < NCLS; c++) begin
        if (cls == pds_pkg::CLS_SUM || cls == c[1:0]) begin
          acc += payload ? payload_hist[c*NUM_BINS + int'(idx)]
                         : size_hist[c*NUM_BINS + int'(idx)];
        end
      end
      return acc;
    endfunction

    function void note_item(pkt_t p);
      result_t r;
      r = '0;
      case (p.command)
        pds_pkg::CMD_RECORD:    r.direction  = record_packet(p);
        pds_pkg::CMD_READ_CNT:  r.read_value = counter_value(p.read_class, p.read_index);
        pds_pkg::CMD_READ_SIZE: r.read_value = bin_value(1'b0, p.read_class, p.read_index);
        default:                r.read_value = bin_value(1'b1, p.read_class, p.read_index);
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] dir, logic [47:0] value);
      result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: direction %0d, read_value %0d", dir, value);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (dir !== want.direction) begin
        $error("direction: expected %0d, actual %0d", want.direction, dir);
        failures++;
      end
      if (value !== want.read_value) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, value);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [pds_pkg::CFG_W-1:0] cfg_wdata;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  stats_scoreboard sb;
  int          sender_idle_pct;
  int          stall_pct;
  logic [47:0] next_stamp;

  packet_direction_statistics_top #(
    .NUM_BINS (NUM_BINS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        sb.note_item('{command: pds_pkg::cmd_t'(in_ch.command), src_ip: in_ch.src_ip,
                       dst_ip: in_ch.dst_ip, frame_len: in_ch.frame_len,
                       ip_len: in_ch.ip_len, payload_len: in_ch.payload_len,
                       proto_kind: in_ch.proto_kind, tcp_flags: in_ch.tcp_flags,
                       time_us: in_ch.time_us, read_class: in_ch.read_class,
                       read_index: in_ch.read_index});
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_result(out_ch.direction, out_ch.read_value);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 80; stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 80; end
      default:       begin sender_idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // Holds valid high until the transfer, then leaves a random gap. Valid stays high
  // when no gap follows, so that back-to-back items need no second assignment.
  task automatic transfer_item(input pkt_t p);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.command     <= p.command;
    in_ch.src_ip      <= p.src_ip;
    in_ch.dst_ip      <= p.dst_ip;
    in_ch.frame_len   <= p.frame_len;
    in_ch.ip_len      <= p.ip_len;
    in_ch.payload_len <= p.payload_len;
    in_ch.proto_kind  <= p.proto_kind;
    in_ch.tcp_flags   <= p.tcp_flags;
    in_ch.time_us     <= p.time_us;
    in_ch.read_class  <= p.read_class;
    in_ch.read_index  <= p.read_index;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] ip, input logic swap);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= pds_pkg::CFG_REF_IP;
    cfg_wdata <= ip;
    @(posedge clk);
    cfg_index <= pds_pkg::CFG_SWAP;
    cfg_wdata <= pds_pkg::CFG_W'(swap);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(ip, swap);
  endtask

  function automatic pkt_t record_of(logic [31:0] src, logic [31:0] dst, logic [15:0] frame,
                                     logic [15:0] iplen, logic [15:0] paylen,
                                     logic [1:0] proto, logic [3:0] flags,
                                     logic [47:0] stamp);
    pkt_t p;
    p = '0;
    p.command     = pds_pkg::CMD_RECORD;
    p.src_ip      = src;
    p.dst_ip      = dst;
    p.frame_len   = frame;
    p.ip_len      = iplen;
    p.payload_len = paylen;
    p.proto_kind  = proto;
    p.tcp_flags   = flags;
    p.time_us     = stamp;
    return p;
  endfunction

  function automatic pkt_t read_of(pds_pkg::cmd_t cmd, logic [1:0] cls, int idx);
    pkt_t p;
    p = '0;
    p.command    = cmd;
    p.read_class = cls;
    p.read_index = 11'(idx);
    return p;
  endfunction

  // Lengths cluster on a few bins so that later reads find non-zero values.
  function automatic logic [15:0] pick_len();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom_range(20, 27));
      5:             return 16'($urandom_range(NUM_BINS - 4, NUM_BINS + 2));
      6:             return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      7, 8:          return 16'($urandom_range(1600));
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic logic [10:0] pick_bin_index();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 11'($urandom_range(20, 27));
      6:                return 11'($urandom_range(NUM_BINS - 4, NUM_BINS + 2));
      7:                return $urandom_range(1) ? 11'(NUM_BINS - 1) : 11'd0;
      8:                return 11'($urandom_range(1600));
      default:          return 11'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(5))
      0, 1:    return sb.ref_ip;
      2:       return 32'h0A00_0001 + $urandom_range(3);
      3:       return sb.ref_ip ^ (32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic pkt_t random_item();
    pkt_t p;
    p.command     = pds_pkg::cmd_t'($urandom_range(3));
    p.src_ip      = $urandom;
    p.dst_ip      = $urandom;
    p.frame_len   = 16'($urandom);
    p.ip_len      = 16'($urandom);
    p.payload_len = 16'($urandom);
    p.proto_kind  = 2'($urandom);
    p.tcp_flags   = 4'($urandom);
    p.time_us     = {16'($urandom), $urandom};
    p.read_class  = 2'($urandom);
    p.read_index  = 11'($urandom);
    if ($urandom_range(99) < 55) begin
      p.command     = pds_pkg::CMD_RECORD;
      p.src_ip      = pick_addr();
      p.dst_ip      = pick_addr();
      if ($urandom_range(3) != 0) p.frame_len = 16'($urandom_range(60, 1518));
      p.ip_len      = pick_len();
      p.payload_len = pick_len();
      // Timestamps mostly advance; now and then one jumps anywhere, backwards too.
      if ($urandom_range(19) != 0) begin
        next_stamp += $urandom_range(1, 5000);
        p.time_us = next_stamp;
      end else begin
        next_stamp = p.time_us;
      end
    end else begin
      p.command = pds_pkg::cmd_t'($urandom_range(1, 3));
      if (p.command == pds_pkg::CMD_READ_CNT) begin
        if ($urandom_range(9) != 0) p.read_index = 11'($urandom_range(7));
      end else begin
        p.read_index = pick_bin_index();
      end
    end
    return p;
  endfunction

  initial begin
    logic [31:0] home;
    logic [31:0] peer;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = pds_pkg::CFG_REF_IP;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = pds_pkg::CMD_RECORD;
    in_ch.src_ip      = '0;
    in_ch.dst_ip      = '0;
    in_ch.frame_len   = '0;
    in_ch.ip_len      = '0;
    in_ch.payload_len = '0;
    in_ch.proto_kind  = '0;
    in_ch.tcp_flags   = '0;
    in_ch.time_us     = '0;
    in_ch.read_class  = '0;
    in_ch.read_index  = '0;
    out_ch.ready      = 1'b0;
    next_stamp        = 48'd100;
    set_idling(IDLE_NONE);
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       apply_config(32'hC0A8_0001, 1'b0);
        1:       apply_config(32'h0000_0000, 1'b1);
        2:       apply_config(32'hFFFF_FFFF, 1'b0);
        default: apply_config($urandom, 1'b1);
      endcase
      if (ph == 0) begin
        home = sb.ref_ip;
        peer = 32'h0A00_0001;
        set_idling(IDLE_NONE);
        // Duration and bins read zero before any packet.
        transfer_item(read_of(pds_pkg::CMD_READ_CNT, pds_pkg::CLS_SUM,
                              int'(pds_pkg::CNT_DURATION)));
        transfer_item(read_of(pds_pkg::CMD_READ_SIZE, pds_pkg::CLS_OUT, 0));
        transfer_item(record_of(home, peer, 16'd0, 16'd0, 16'd0, pds_pkg::PROTO_TCP, 4'hF,
                                48'hFFFF_FFFF_FFF0));
        transfer_item(record_of(peer, home, 16'hFFFF, 16'(NUM_BINS - 2), 16'(NUM_BINS - 1),
                                pds_pkg::PROTO_UDP, 4'h0, 48'hFFFF_FFFF_FFFF));
        // Timestamp going backwards, so the duration wraps.
        transfer_item(record_of(peer, 32'h0A00_0002, 16'd1514, 16'(NUM_BINS - 1), 16'hFFFF,
                                PROTO_NONE, 4'hF, 48'd5));
        transfer_item(record_of(home, home, 16'd60, 16'hFFFF, 16'(NUM_BINS),
                                PROTO_UNKNOWN, 4'hF, 48'd1));
        transfer_item(record_of(peer, home, 16'd100, 16'(NUM_BINS - 2), 16'd0,
                                pds_pkg::PROTO_TCP, 4'b0101, 48'd7));
        transfer_item(record_of(home, peer, 16'd100, 16'd20, 16'(NUM_BINS - 2),
                                pds_pkg::PROTO_TCP, 4'b1010, 48'd9));
        for (int i = 0; i <= int'(pds_pkg::CNT_DURATION); i++) begin
          transfer_item(read_of(pds_pkg::CMD_READ_CNT, pds_pkg::CLS_SUM, i));
        end
        transfer_item(read_of(pds_pkg::CMD_READ_CNT, pds_pkg::CLS_OUT,
                              int'(pds_pkg::CNT_DURATION) + 1));
        transfer_item(read_of(pds_pkg::CMD_READ_CNT, pds_pkg::CLS_IN, 2047));
        transfer_item(read_of(pds_pkg::CMD_READ_SIZE, pds_pkg::CLS_SUM, NUM_BINS - 1));
        transfer_item(read_of(pds_pkg::CMD_READ_PAY, pds_pkg::CLS_IN, NUM_BINS - 1));
        transfer_item(read_of(pds_pkg::CMD_READ_SIZE, pds_pkg::CLS_SUM, NUM_BINS));
        transfer_item(read_of(pds_pkg::CMD_READ_PAY, pds_pkg::CLS_OTHER, 2047));
        transfer_item(read_of(pds_pkg::CMD_READ_SIZE, pds_pkg::CLS_IN, NUM_BINS - 2));
        transfer_item(read_of(pds_pkg::CMD_READ_CNT, pds_pkg::CLS_OTHER,
                              int'(pds_pkg::CNT_DURATION)));
      end
      for (int blk = 0; blk < 4; blk++) begin
        set_idling(idle_mode_t'((ph + blk) % 4));
        for (int n = 0; n < 95; n++) transfer_item(random_item());
        // The sender holds off once mid-phase until every result has come back.
        if (ph == 1 && blk == 1) drain();
      end
    end

    drain();
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
